FILE: sv/lsg_pkg.sv
// ============================================================================
// lsg_pkg - shared definitions for the life strip generation block
// Widths, codes and the record types passed between front end, queue and back end.
// ============================================================================
package lsg_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int ROW_BITS   = 64;
    localparam int COL_BITS   = $clog2(ROW_BITS);
    localparam int WIDTH_BITS = 7;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(64);

    // Register indexes on the configuration port (one word every four bytes).
    localparam logic REG_ROW_WIDTH = 1'b0;

    // Number of rows of a strip that must be held before a result appears.
    localparam logic [1:0] SEEN_FULL = 2'd2;

    // Neighbour counts of the B3/S23 rule.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef logic [ROW_BITS-1:0] row_t;
    typedef logic [COL_BITS-1:0] col_t;

    // Three-row window handed from the front end to the back end.
    typedef struct packed {
        row_t above;
        row_t middle;
        row_t below;
        logic last;
    } window_t;

    typedef struct packed {
        logic       push;
        logic [1:0] seen;
    } front_status_t;

    typedef struct packed {
        logic [QCNT_BITS-1:0] level;
        logic                 full;
        logic                 empty;
    } queue_status_t;

endpackage

FILE: sv/lsg_front.sv
// ============================================================================
// lsg_front - row intake and window builder
// Holds the two previous rows of the strip and emits a window per result row.
// ============================================================================
module lsg_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lsg_pkg::row_t          in_row,
    input  logic                   in_last,
    input  logic                   q_full,
    output lsg_pkg::window_t       win,
    output lsg_pkg::front_status_t status
);

    lsg_pkg::row_t above_reg;
    lsg_pkg::row_t above_next;
    lsg_pkg::row_t middle_reg;
    lsg_pkg::row_t middle_next;
    logic [1:0]    seen_reg;
    logic [1:0]    seen_next;
    logic          accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        above_next  = above_reg;
        middle_next = middle_reg;
        seen_next   = seen_reg;
        if (accept)
        begin
            above_next  = middle_reg;
            middle_next = in_row;
            if (seen_reg < lsg_pkg::SEEN_FULL)
            begin
                seen_next = seen_reg + 2'd1;
            end
            // The bottom halo closes the strip; the next row is a new top halo.
            if (in_last)
            begin
                above_next  = '0;
                middle_next = '0;
                seen_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg  <= '0;
            middle_reg <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            above_reg  <= above_next;
            middle_reg <= middle_next;
            seen_reg   <= seen_next;
        end
    end

    assign win.above  = above_reg;
    assign win.middle = middle_reg;
    assign win.below  = in_row;
    assign win.last   = in_last;

    assign status.push = accept && (seen_reg == lsg_pkg::SEEN_FULL);
    assign status.seen = seen_reg;

endmodule

FILE: sv/lsg_queue.sv
// ============================================================================
// lsg_queue - window queue between front end and back end
// A two-entry first-in first-out buffer of three-row windows.
// ============================================================================
module lsg_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lsg_pkg::window_t       push_data,
    input  logic                   pop,
    output lsg_pkg::window_t       pop_data,
    output lsg_pkg::queue_status_t status
);

    lsg_pkg::window_t                 entry_reg [lsg_pkg::QDEPTH];
    logic [lsg_pkg::QPTR_BITS-1:0]    wr_ptr_reg;
    logic [lsg_pkg::QPTR_BITS-1:0]    wr_ptr_next;
    logic [lsg_pkg::QPTR_BITS-1:0]    rd_ptr_reg;
    logic [lsg_pkg::QPTR_BITS-1:0]    rd_ptr_next;
    logic [lsg_pkg::QCNT_BITS-1:0]    level_reg;
    logic [lsg_pkg::QCNT_BITS-1:0]    level_next;
    logic                             do_push;
    logic                             do_pop;

    assign status.level = level_reg;
    assign status.full  = (level_reg == lsg_pkg::QCNT_BITS'(lsg_pkg::QDEPTH));
    assign status.empty = (level_reg == '0);

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    function automatic logic [lsg_pkg::QPTR_BITS-1:0] ptr_inc(
        input logic [lsg_pkg::QPTR_BITS-1:0] p
    );
        if (p == lsg_pkg::QPTR_BITS'(lsg_pkg::QDEPTH - 1))
        begin
            return '0;
        end
        return p + lsg_pkg::QPTR_BITS'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + lsg_pkg::QCNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - lsg_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];

endmodule

FILE: sv/lsg_back.sv
// ============================================================================
// lsg_back - generation update and result register
// Applies the B3/S23 rule to all columns of a window and holds the result.
// ============================================================================
module lsg_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [lsg_pkg::WIDTH_BITS-1:0] row_width,
    input  logic                           q_valid,
    input  lsg_pkg::window_t               q_data,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lsg_pkg::row_t                  out_cells,
    output logic                           out_end
);

    logic [lsg_pkg::WIDTH_BITS-1:0] eff_width;
    logic [lsg_pkg::WIDTH_BITS-1:0] width_m1;
    lsg_pkg::col_t                  last_col;
    lsg_pkg::row_t                  up_l;
    lsg_pkg::row_t                  up_r;
    lsg_pkg::row_t                  mid_l;
    lsg_pkg::row_t                  mid_r;
    lsg_pkg::row_t                  dn_l;
    lsg_pkg::row_t                  dn_r;
    logic [3:0]                     count [lsg_pkg::ROW_BITS];
    lsg_pkg::row_t                  gen;
    logic                           valid_reg;
    logic                           valid_next;
    lsg_pkg::row_t                  cells_reg;
    logic                           end_reg;

    // Value of the left neighbour of every column, wrapping at last_col.
    function automatic lsg_pkg::row_t from_left(input lsg_pkg::row_t r, input lsg_pkg::col_t lc);
        lsg_pkg::row_t res;
        res    = r << 1;
        res[0] = r[lc];
        return res;
    endfunction

    // Value of the right neighbour of every column, wrapping at last_col.
    function automatic lsg_pkg::row_t from_right(input lsg_pkg::row_t r, input lsg_pkg::col_t lc);
        lsg_pkg::row_t res;
        res = r >> 1;
        for (int j = 0; j < lsg_pkg::ROW_BITS; j++)
        begin
            if (lsg_pkg::COL_BITS'(j) == lc)
            begin
                res[j] = r[0];
            end
        end
        return res;
    endfunction

    always_comb
    begin
        if (row_width == '0)
        begin
            eff_width = lsg_pkg::WIDTH_BITS'(1);
        end
        else if (row_width > lsg_pkg::WIDTH_BITS'(lsg_pkg::MAX_WIDTH))
        begin
            eff_width = lsg_pkg::WIDTH_BITS'(lsg_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_width = row_width;
        end
        width_m1 = eff_width - lsg_pkg::WIDTH_BITS'(1);
        last_col = width_m1[lsg_pkg::COL_BITS-1:0];
    end

    assign up_l  = from_left(q_data.above, last_col);
    assign up_r  = from_right(q_data.above, last_col);
    assign mid_l = from_left(q_data.middle, last_col);
    assign mid_r = from_right(q_data.middle, last_col);
    assign dn_l  = from_left(q_data.below, last_col);
    assign dn_r  = from_right(q_data.below, last_col);

    always_comb
    begin
        for (int j = 0; j < lsg_pkg::ROW_BITS; j++)
        begin
            count[j] = 4'(up_l[j]) + 4'(q_data.above[j]) + 4'(up_r[j])
                     + 4'(mid_l[j]) + 4'(mid_r[j])
                     + 4'(dn_l[j]) + 4'(q_data.below[j]) + 4'(dn_r[j]);
            gen[j] = 1'b0;
            if (lsg_pkg::COL_BITS'(j) <= last_col)
            begin
                gen[j] = (count[j] == lsg_pkg::BIRTH_COUNT)
                      || (q_data.middle[j] && (count[j] == lsg_pkg::SURVIVE_COUNT));
            end
        end
    end

    assign q_pop = q_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cells_reg <= gen;
            end_reg   <= q_data.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_cells = cells_reg;
    assign out_end   = end_reg;

endmodule

FILE: sv/life_strip_generation.sv
// ============================================================================
// life_strip_generation - one Conway life generation over a strip of rows
// Streams rows in, streams next-generation rows out, columns wrap at row_width.
// ============================================================================
// A strip arrives on the slave stream as whole rows, one row per transaction:
// the top halo row, the local rows, and the bottom halo row, which carries
// tlast. From the third row on, every row produces one master transaction with
// the next generation of the row before it, and the result for the last local
// row carries tlast. A strip of fewer than three rows gives no result. The
// block takes one row per clock cycle and sustains that rate: a row is
// accepted whenever the two-entry window queue between the intake and the
// update logic has room. Its window is written into the queue, and all
// columns are updated while it is at the queue head, so the result is
// loaded into the output register when the window is popped, which waits
// while the output register holds a result the master side has not taken.
// The row width register is read when a result is computed, so it should only
// be rewritten while no strip is in flight; a width of zero behaves as one and
// anything above 64 behaves as 64. There is no clearing pass after reset.
// ============================================================================
module life_strip_generation (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: tdata = row_cells[63:0]; tlast = last_row
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    // master stream: tdata = next_cells[63:0]; tlast = strip_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [lsg_pkg::WIDTH_BITS-1:0] width_reg;
    logic [lsg_pkg::WIDTH_BITS-1:0] width_next;
    logic                           cfg_write;

    lsg_pkg::window_t               front_win;
    lsg_pkg::window_t               queue_head;
    lsg_pkg::front_status_t         front_stat;
    lsg_pkg::queue_status_t         queue_stat;
    logic                           queue_pop;

    // ------------------------------------------------------------------
    // Configuration: a single register at byte address zero. The port
    // never inserts wait states; writes elsewhere are ignored and read
    // back as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == lsg_pkg::REG_ROW_WIDTH);

    always_comb
    begin
        width_next = width_reg;
        if (cfg_write)
        begin
            width_next = pwdata[lsg_pkg::WIDTH_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= lsg_pkg::WIDTH_RESET;
        end
        else
        begin
            width_reg <= width_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == lsg_pkg::REG_ROW_WIDTH)
        begin
            prdata = {{(32 - lsg_pkg::WIDTH_BITS){1'b0}}, width_reg};
        end
    end

    // ------------------------------------------------------------------
    // Front end: keeps the two rows above the incoming one and issues a
    // three-row window for every row that completes one.
    // ------------------------------------------------------------------
    lsg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_row   (s_tdata),
        .in_last  (s_tlast),
        .q_full   (queue_stat.full),
        .win      (front_win),
        .status   (front_stat)
    );

    // ------------------------------------------------------------------
    // Window queue: lets the intake run on while a result is stalled.
    // ------------------------------------------------------------------
    lsg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_stat.push),
        .push_data (front_win),
        .pop       (queue_pop),
        .pop_data  (queue_head),
        .status    (queue_stat)
    );

    // ------------------------------------------------------------------
    // Back end: all columns are updated in parallel and the new row is
    // held in the output register until the master side takes it.
    // ------------------------------------------------------------------
    lsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_width (width_reg),
        .q_valid   (!queue_stat.empty),
        .q_data    (queue_head),
        .q_pop     (queue_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cells (m_tdata),
        .out_end   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // The row counter saturates at two and never reaches three.
    assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.seen != 2'd3)
        else $error("row counter left its range");

    // A row carrying tlast always restarts the strip.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (front_stat.seen == 2'd0))
        else $error("strip did not restart after its bottom halo row");

    // A window is only queued when the queue has room, so the fill level
    // never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_stat.level <= lsg_pkg::QCNT_BITS'(lsg_pkg::QDEPTH))
        else $error("window queue overflow");

    // Every accepted row that completes a window lands in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_stat.push && !queue_pop)
            |=> (queue_stat.level == $past(queue_stat.level) + lsg_pkg::QCNT_BITS'(1)))
        else $error("window lost on its way into the queue");

endmodule
